// ===== sv/lprl_pkg.sv =====
// Shared types, constants and helpers for the longest prefix route lookup block.
package lprl_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned NUM_PORTS   = 16;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IFACE_W = 4;
  localparam int unsigned TTL_W   = 8;
  localparam int unsigned MAX_LEN = 32;

  // Input beat layout, lowest bit first.
  localparam int unsigned IN_PREFIX_LO = 0;
  localparam int unsigned IN_LEN_LO    = IN_PREFIX_LO + ADDR_W;
  localparam int unsigned IN_HASNH_LO  = IN_LEN_LO + LEN_W;
  localparam int unsigned IN_NH_LO     = IN_HASNH_LO + 1;
  localparam int unsigned IN_IFACE_LO  = IN_NH_LO + ADDR_W;
  localparam int unsigned IN_DEST_LO   = IN_IFACE_LO + IFACE_W;
  localparam int unsigned IN_TTL_LO    = IN_DEST_LO + ADDR_W;
  localparam int unsigned IN_BITS      = IN_TTL_LO + TTL_W;
  localparam int unsigned IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_W    = 1;

  // Output beat layout, lowest bit first.
  localparam int unsigned OUT_IFACE_LO = 0;
  localparam int unsigned OUT_HOP_LO   = OUT_IFACE_LO + IFACE_W;
  localparam int unsigned OUT_TTL_LO   = OUT_HOP_LO + ADDR_W;
  localparam int unsigned OUT_BITS     = OUT_TTL_LO + TTL_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W   = 3;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_ROUTE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    STATUS_FORWARDED   = 3'd0,
    STATUS_TTL_EXPIRED = 3'd1,
    STATUS_NO_ROUTE    = 3'd2,
    STATUS_ADDED       = 3'd3,
    STATUS_FULL        = 3'd4
  } status_t;

  typedef struct packed {
    logic [IFACE_W-1:0] port;
    logic               hop_valid;
    logic [ADDR_W-1:0]  hop;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  prefix;
  } route_entry_t;

  localparam int unsigned ENTRY_W = $bits(route_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // input beat accepted this cycle
    logic rd_issue;  // read the entry at the scan index
    logic out_load;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_add;      // beat on the input is an add
    logic in_ttl_low;  // beat on the input carries a TTL of 0 or 1
    logic count_zero;  // no routes stored
    logic scan_last;   // scan index points at the last stored route
    logic out_free;    // output register can take a result this cycle
  } ctrl_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Mask of the top len bits; len is at most 32 here.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== sv/lprl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module lprl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lprl_ctrl.sv =====
// Controller state machine that sequences adds, route scans and result hand-off.
module lprl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lprl_pkg::ctrl_sts_t sts,
  output lprl_pkg::ctrl_cmd_t cmd
);
  import lprl_pkg::*;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_add || sts.in_ttl_low || sts.count_zero) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_LAST;
        end
      end
      // The read of the last entry is compared in this cycle.
      ST_LAST: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SCAN) || (state == ST_DONE))
    else $error("accepted beat did not start a scan or finish");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && sts.scan_last |=> (state == ST_LAST) ##1 (state == ST_DONE))
    else $error("scan did not drain into done");

endmodule

// ===== sv/lprl_dpath.sv =====
// Datapath: route table memory, scan compare, best-match registers and output register.
module lprl_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lprl_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [lprl_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lprl_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [lprl_pkg::OUT_USER_W-1:0]     m_tuser,
  input  lprl_pkg::ctrl_cmd_t                 cmd,
  output lprl_pkg::ctrl_sts_t                 sts
);
  import lprl_pkg::*;

  // Input field extraction.
  logic [ADDR_W-1:0]  in_prefix;
  logic [LEN_W-1:0]   in_len;
  logic               in_has_nh;
  logic [ADDR_W-1:0]  in_nh;
  logic [IFACE_W-1:0] in_iface;
  logic [ADDR_W-1:0]  in_dest;
  logic [TTL_W-1:0]   in_ttl;
  logic               in_add;
  logic [LEN_W-1:0]   sat_len;

  assign in_prefix = s_tdata[IN_PREFIX_LO +: ADDR_W];
  assign in_len    = s_tdata[IN_LEN_LO +: LEN_W];
  assign in_has_nh = s_tdata[IN_HASNH_LO];
  assign in_nh     = s_tdata[IN_NH_LO +: ADDR_W];
  assign in_iface  = s_tdata[IN_IFACE_LO +: IFACE_W];
  assign in_dest   = s_tdata[IN_DEST_LO +: ADDR_W];
  assign in_ttl    = s_tdata[IN_TTL_LO +: TTL_W];
  assign in_add    = (opcode_t'(s_tuser[0]) == OP_ADD);
  assign sat_len   = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;

  // Table bookkeeping.
  logic [CNT_W-1:0] count;
  logic             full;
  logic             do_write;
  route_entry_t     wr_entry;

  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign do_write = cmd.load && in_add && !full;

  always_comb begin
    wr_entry.port      = in_iface;
    wr_entry.hop_valid = in_has_nh;
    wr_entry.hop       = in_has_nh ? in_nh : '0;
    wr_entry.len       = sat_len;
    wr_entry.prefix    = in_prefix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_write) begin
      count <= count + CNT_W'(1);
    end
  end

  // Held fields of the beat in progress.
  logic             op_add;
  logic             add_full;
  logic             ttl_low;
  logic [ADDR_W-1:0] dest;
  logic [TTL_W-1:0]  ttl;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_add   <= in_add;
      add_full <= full;
      ttl_low  <= (in_ttl <= TTL_W'(1));
      dest     <= in_dest;
      ttl      <= in_ttl;
    end
  end

  // Scan: one read issued per cycle, compared the cycle after.
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pending;
  logic [ENTRY_W-1:0] rd_word;
  route_entry_t     rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.rd_issue;
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  lprl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (do_write),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (cmd.rd_issue),
    .raddr (rd_idx),
    .rdata (rd_word)
  );

  assign rd_entry = route_entry_t'(rd_word);

  logic               found;
  logic [LEN_W-1:0]   best_len;
  logic [IFACE_W-1:0] best_port;
  logic               best_hop_valid;
  logic [ADDR_W-1:0]  best_hop;
  logic               hit;

  // Ties go to the later entry, so equal length replaces the current best.
  assign hit = (((rd_entry.prefix ^ dest) & prefix_mask(rd_entry.len)) == '0) &&
               (rd_entry.len >= best_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (rd_pending && hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_len <= '0;
    end else if (rd_pending && hit) begin
      best_len       <= rd_entry.len;
      best_port      <= rd_entry.port;
      best_hop_valid <= rd_entry.hop_valid;
      best_hop       <= rd_entry.hop;
    end
  end

  // Result assembly.
  status_t            res_status;
  logic [IFACE_W-1:0] res_iface;
  logic [ADDR_W-1:0]  res_hop;
  logic [TTL_W-1:0]   res_ttl;
  logic               port_ok;

  assign port_ok = (32'(best_port) < NUM_PORTS);

  always_comb begin
    res_status = STATUS_NO_ROUTE;
    res_iface  = '0;
    res_hop    = '0;
    res_ttl    = '0;
    if (op_add) begin
      res_status = add_full ? STATUS_FULL : STATUS_ADDED;
    end else if (ttl_low) begin
      res_status = STATUS_TTL_EXPIRED;
    end else if (found && port_ok) begin
      res_status = STATUS_FORWARDED;
      res_iface  = best_port;
      res_hop    = best_hop_valid ? best_hop : dest;
      res_ttl    = ttl - TTL_W'(1);
    end
  end

  // Output register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_USER_W-1:0] out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_W'({res_ttl, res_hop, res_iface});
      out_user <= OUT_USER_W'(res_status);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  always_comb begin
    sts.in_add     = in_add;
    sts.in_ttl_low = (in_ttl <= TTL_W'(1));
    sts.count_zero = (count == '0);
    sts.scan_last  = (CNT_W'(rd_idx) == (count - CNT_W'(1)));
    sts.out_free   = !out_valid || m_tready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (CNT_W'(rd_idx) < count))
    else $error("scan read beyond stored routes");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a loaded result");

endmodule

// ===== sv/longest_prefix_route_lookup_core.sv =====
// Top level of the IPv4 longest prefix match route table.
//
// Input channel s_*: one beat is one operation. s_tuser[0] is the opcode
// (0 add a route, 1 route a datagram). An add stores the route in the next
// free table entry; a route looks up the destination address.
// Output channel m_*: exactly one result beat per input beat, in order.
// m_tuser holds the status code, m_tdata the interface, next hop and TTL.
// An add, a TTL drop or a lookup on an empty table skips the scan and goes
// straight to the result. A lookup scans every stored route, one entry per
// cycle from the single read port of the table memory.
// One operation is in progress at a time; s_tready is high only between
// operations. A finished result sits in the output register, and the next
// operation is accepted while it waits. If the receiver stalls, the block
// holds the following result until the register frees up.
// Reset empties the table (the count of stored routes goes to zero) and
// drops any result in flight; no clearing pass is needed.
module longest_prefix_route_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // new route address, mask length, gateway flag, gateway address,
  // output port, destination address, TTL, zero fill
  input  logic [lprl_pkg::IN_DATA_W-1:0]      s_tdata,
  // opcode
  input  logic [lprl_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_interface, hop_addr_out, ttl_out, zero fill
  output logic [lprl_pkg::OUT_DATA_W-1:0]     m_tdata,
  // status
  output logic [lprl_pkg::OUT_USER_W-1:0]     m_tuser
);
  import lprl_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lprl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lprl_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
